// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/fbpeq_pkg.sv
// ----------------------------------------------------------------------------
// fbpeq_pkg
// Types, constants and command encoding shared by the stereo peaking EQ.
// ----------------------------------------------------------------------------
package fbpeq_pkg;

  // Sizes
  localparam int NUM_BANDS_DEF = 4;
  localparam int SAMPLE_BITS   = 24;
  localparam int NUM_SLOTS     = 5;
  localparam int HIST_WORDS    = 4;
  localparam int COEF_W        = 32;
  localparam int HIST_W        = 32;
  localparam int MUL_A_W       = 34;
  localparam int MUL_B_W       = 32;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;
  localparam int ACC_W         = 67;
  localparam int W_W           = 34;
  localparam int GAIN_W        = 15;
  localparam int MIX_W         = 17;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 17;

  // Fixed-point positions
  localparam int COEF_FRAC = 28;
  localparam int GAIN_FRAC = 13;
  localparam int MIX_FRAC  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX     = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8192);
  localparam logic [MIX_W-1:0]  MIX_ONE    = MIX_W'(65536);

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // History word offsets within one band
  localparam int HX1 = 0;
  localparam int HX2 = 1;
  localparam int HY1 = 2;
  localparam int HY2 = 3;

  // Coefficient 1.0 in Q3.28 (pass-through b0)
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< COEF_FRAC;

  // Rounding offsets
  localparam logic signed [ACC_W-1:0] ACC_HALF_BQ   = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF_GAIN = ACC_W'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF_MIX  = ACC_W'(1) <<< (MIX_FRAC - 1);

  // Saturation limits of a history word
  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic [1:0]                    coef_band;
    logic [2:0]                    coef_slot;
    logic signed [COEF_W-1:0]      coef_value;
  } eq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } eq_out_t;

  typedef enum logic [1:0] {
    A_COEF,
    A_X,
    A_DRY,
    A_W
  } a_sel_e;

  typedef enum logic [2:0] {
    B_X,
    B_HIST,
    B_GAIN,
    B_INVM,
    B_M
  } b_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_INIT_BQ,
    ACC_INIT_GAIN,
    ACC_INIT_MIX,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    HW_H0,
    HW_X,
    HW_H2,
    HW_Y
  } hw_sel_e;

  // Controller to datapath command word
  typedef struct packed {
    logic    in_take;   // input item accepted this cycle
    logic    x_load;    // stage input <= right dry sample
    logic    ch;        // channel being processed
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    logic    y_fin;     // stage input <= saturated biquad output
    logic    w_load;    // gained sample <= accumulator
    logic    res_load;  // hold left result
    logic    out_load;  // publish result to the output register
    logic    coef_b0;   // coefficient read addresses a b0 slot
    logic    hist_we;
    hw_sel_e hw_sel;
    logic    h0_cap;    // capture x1 read data
    logic    h2_cap;    // capture y1 read data
  } eq_cmd_t;

endpackage

// File: hdl/fbpeq_ram.sv
// ----------------------------------------------------------------------------
// fbpeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/fbpeq_ctrl.sv
// ----------------------------------------------------------------------------
// fbpeq_ctrl
// Sequencer: walks bands, gain and mix steps and drives the datapath.
// ----------------------------------------------------------------------------
module fbpeq_ctrl #(
  parameter int NUM_BANDS = fbpeq_pkg::NUM_BANDS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_kind_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output fbpeq_pkg::eq_cmd_t     cmd_o,
  output logic [COEF_AW-1:0]     coef_raddr_o,
  output logic [HIST_AW-1:0]     hist_raddr_o,
  output logic [HIST_AW-1:0]     hist_waddr_o
);

  localparam int COEF_AW = $clog2(NUM_BANDS * fbpeq_pkg::NUM_SLOTS);
  localparam int HIST_AW = $clog2(2 * NUM_BANDS * fbpeq_pkg::HIST_WORDS);
  localparam int BAND_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BAND,
    S_POST,
    S_PUB
  } state_e;

  state_e               state_q;
  logic [2:0]           step_q;
  logic [BAND_W-1:0]    band_q;
  logic                 ch_q;
  logic [COEF_AW-1:0]   cbase_q;
  logic [HIST_AW-1:0]   hbase_q;
  logic                 out_valid_q;
  logic                 in_take;
  logic [HIST_AW-1:0]   hw_off;
  fbpeq_pkg::eq_cmd_t   cmd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // coefficient k is read at step k, history word k-1 at step k
  assign coef_raddr_o = cbase_q + COEF_AW'(step_q);
  assign hist_raddr_o = hbase_q + HIST_AW'(step_q - 3'd1);
  assign hist_waddr_o = hbase_q + hw_off;

  always_comb begin
    cmd         = '0;
    cmd.a_sel   = fbpeq_pkg::A_COEF;
    cmd.b_sel   = fbpeq_pkg::B_X;
    cmd.acc_op  = fbpeq_pkg::ACC_HOLD;
    cmd.hw_sel  = fbpeq_pkg::HW_H0;
    cmd.in_take = in_take;
    cmd.ch      = ch_q;
    hw_off      = '0;
    unique case (state_q)
      S_IDLE: begin
      end
      S_BAND: begin
        unique case (step_q)
          3'd0: begin
            cmd.coef_b0 = 1'b1;
          end
          3'd1: begin
            cmd.b_sel  = fbpeq_pkg::B_X;
            cmd.acc_op = fbpeq_pkg::ACC_INIT_BQ;
          end
          3'd2: begin
            cmd.b_sel  = fbpeq_pkg::B_HIST;
            cmd.acc_op = fbpeq_pkg::ACC_ADD;
            cmd.h0_cap = 1'b1;
          end
          3'd3: begin
            cmd.b_sel   = fbpeq_pkg::B_HIST;
            cmd.acc_op  = fbpeq_pkg::ACC_ADD;
            cmd.hist_we = 1'b1;
            cmd.hw_sel  = fbpeq_pkg::HW_H0;
            hw_off      = HIST_AW'(fbpeq_pkg::HX2);
          end
          3'd4: begin
            cmd.b_sel   = fbpeq_pkg::B_HIST;
            cmd.acc_op  = fbpeq_pkg::ACC_ADD;
            cmd.h2_cap  = 1'b1;
            cmd.hist_we = 1'b1;
            cmd.hw_sel  = fbpeq_pkg::HW_X;
            hw_off      = HIST_AW'(fbpeq_pkg::HX1);
          end
          3'd5: begin
            cmd.b_sel   = fbpeq_pkg::B_HIST;
            cmd.acc_op  = fbpeq_pkg::ACC_SUB;
            cmd.hist_we = 1'b1;
            cmd.hw_sel  = fbpeq_pkg::HW_H2;
            hw_off      = HIST_AW'(fbpeq_pkg::HY2);
          end
          3'd6: begin
            cmd.acc_op = fbpeq_pkg::ACC_SUB;
          end
          3'd7: begin
            cmd.y_fin   = 1'b1;
            cmd.hist_we = 1'b1;
            cmd.hw_sel  = fbpeq_pkg::HW_Y;
            hw_off      = HIST_AW'(fbpeq_pkg::HY1);
          end
        endcase
      end
      S_POST: begin
        unique case (step_q)
          3'd0: begin
            cmd.a_sel  = fbpeq_pkg::A_X;
            cmd.b_sel  = fbpeq_pkg::B_GAIN;
            cmd.acc_op = fbpeq_pkg::ACC_INIT_GAIN;
          end
          3'd1: begin
            cmd.acc_op = fbpeq_pkg::ACC_ADD;
          end
          3'd2: begin
            cmd.w_load = 1'b1;
            cmd.a_sel  = fbpeq_pkg::A_DRY;
            cmd.b_sel  = fbpeq_pkg::B_INVM;
            cmd.acc_op = fbpeq_pkg::ACC_INIT_MIX;
          end
          3'd3: begin
            cmd.a_sel  = fbpeq_pkg::A_W;
            cmd.b_sel  = fbpeq_pkg::B_M;
            cmd.acc_op = fbpeq_pkg::ACC_ADD;
          end
          3'd4: begin
            cmd.acc_op = fbpeq_pkg::ACC_ADD;
          end
          3'd5: begin
            cmd.res_load = !ch_q;
            cmd.x_load   = !ch_q;
          end
          default: begin
          end
        endcase
      end
      S_PUB: begin
        cmd.out_load = !out_valid_q || out_ready_i;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      band_q      <= '0;
      ch_q        <= 1'b0;
      cbase_q     <= '0;
      hbase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_take && (in_kind_i == fbpeq_pkg::KIND_SAMPLE)) begin
            state_q <= S_BAND;
            step_q  <= '0;
            band_q  <= '0;
            ch_q    <= 1'b0;
            cbase_q <= '0;
            hbase_q <= '0;
          end
        end
        S_BAND: begin
          if (step_q == 3'd7) begin
            step_q  <= '0;
            cbase_q <= COEF_AW'(cbase_q + COEF_AW'(fbpeq_pkg::NUM_SLOTS));
            hbase_q <= HIST_AW'(hbase_q + HIST_AW'(fbpeq_pkg::HIST_WORDS));
            if (band_q == BAND_W'(NUM_BANDS - 1)) begin
              band_q  <= '0;
              state_q <= S_POST;
            end else begin
              band_q <= band_q + 1'b1;
            end
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_POST: begin
          if (step_q == 3'd5) begin
            step_q <= '0;
            if (!ch_q) begin
              ch_q    <= 1'b1;
              cbase_q <= '0;
              state_q <= S_BAND;
            end else begin
              state_q <= S_PUB;
            end
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_PUB: begin
          if (cmd.out_load) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: hdl/fbpeq_dpath.sv
// ----------------------------------------------------------------------------
// fbpeq_dpath
// Shared multiplier, accumulator, coefficient and history stores, config.
// ----------------------------------------------------------------------------
module fbpeq_dpath #(
  parameter int NUM_BANDS = fbpeq_pkg::NUM_BANDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbpeq_pkg::eq_cmd_t                  cmd_i,
  input  fbpeq_pkg::eq_in_t                   in_item_i,
  input  logic                                cfg_we_i,
  input  logic [fbpeq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fbpeq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [COEF_AW-1:0]                  coef_raddr_i,
  input  logic [HIST_AW-1:0]                  hist_raddr_i,
  input  logic [HIST_AW-1:0]                  hist_waddr_i,
  output fbpeq_pkg::eq_out_t                  out_item_o
);

  localparam int COEF_DEPTH = NUM_BANDS * fbpeq_pkg::NUM_SLOTS;
  localparam int HIST_DEPTH = 2 * NUM_BANDS * fbpeq_pkg::HIST_WORDS;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SB         = fbpeq_pkg::SAMPLE_BITS;
  localparam int ACC_W      = fbpeq_pkg::ACC_W;
  localparam int YSH_W      = ACC_W - fbpeq_pkg::COEF_FRAC;
  localparam int OSH_W      = ACC_W - fbpeq_pkg::MIX_FRAC;
  localparam int HW         = fbpeq_pkg::HIST_W;

  // config
  logic [fbpeq_pkg::GAIN_W-1:0] gain_q;
  logic [fbpeq_pkg::MIX_W-1:0]  wet_q;
  logic [fbpeq_pkg::MIX_W-1:0]  mix_m;
  logic [fbpeq_pkg::MIX_W-1:0]  inv_m;

  // stores
  logic [COEF_DEPTH-1:0]        cvld_q;
  logic [HIST_DEPTH-1:0]        hvld_q;
  logic                         cvld_rd_q;
  logic                         cb0_rd_q;
  logic                         hvld_rd_q;
  logic [fbpeq_pkg::COEF_W-1:0] cram_rd;
  logic [HW-1:0]                hram_rd;
  logic                         cw_en;
  logic [COEF_AW-1:0]           cw_addr;
  logic signed [fbpeq_pkg::COEF_W-1:0] coef_rd;
  logic signed [HW-1:0]         hist_rd;
  logic signed [HW-1:0]         hist_wdata;

  // arithmetic
  logic signed [SB-1:0]                dry_l_q, dry_r_q, dry_sel;
  logic signed [HW-1:0]                x_q, h0_q, h2_q;
  logic signed [fbpeq_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fbpeq_pkg::MUL_B_W-1:0] mul_b;
  logic signed [fbpeq_pkg::PROD_W-1:0]  mul_p, prod_q;
  logic signed [ACC_W-1:0]             acc_q, acc_d;
  logic signed [fbpeq_pkg::W_W-1:0]    w_q;
  logic signed [YSH_W-1:0]             ysh;
  logic signed [HW-1:0]                y_sat;
  logic signed [OSH_W-1:0]             osh;
  logic signed [SB-1:0]                o_sat;
  logic signed [SB-1:0]                res_l_q;
  fbpeq_pkg::eq_out_t                  out_q;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= fbpeq_pkg::GAIN_RESET;
      wet_q  <= fbpeq_pkg::MIX_ONE;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fbpeq_pkg::CFG_OUTPUT_GAIN) begin
        gain_q <= cfg_data_i[fbpeq_pkg::GAIN_W-1:0];
      end else if (cfg_idx_i == fbpeq_pkg::CFG_WET_MIX) begin
        wet_q <= cfg_data_i[fbpeq_pkg::MIX_W-1:0];
      end
    end
  end

  // mix above unity clamps to unity
  assign mix_m = (wet_q > fbpeq_pkg::MIX_ONE) ? fbpeq_pkg::MIX_ONE : wet_q;
  assign inv_m = fbpeq_pkg::MIX_ONE - mix_m;

  // ---------------- coefficient store ----------------
  assign cw_en = cmd_i.in_take && (in_item_i.kind == fbpeq_pkg::KIND_COEF) &&
                 (32'(in_item_i.coef_band) < NUM_BANDS) &&
                 (32'(in_item_i.coef_slot) < fbpeq_pkg::NUM_SLOTS);
  assign cw_addr = COEF_AW'(32'(in_item_i.coef_band) * fbpeq_pkg::NUM_SLOTS +
                            32'(in_item_i.coef_slot));

  fbpeq_ram #(
    .WIDTH (fbpeq_pkg::COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cw_en),
    .waddr_i (cw_addr),
    .wdata_i (in_item_i.coef_value),
    .raddr_i (coef_raddr_i),
    .rdata_o (cram_rd)
  );

  fbpeq_ram #(
    .WIDTH (HW),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist_we),
    .waddr_i (hist_waddr_i),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr_i),
    .rdata_o (hram_rd)
  );

  // written-once flags; unwritten entries read as the reset table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q    <= '0;
      hvld_q    <= '0;
      cvld_rd_q <= 1'b0;
      cb0_rd_q  <= 1'b0;
      hvld_rd_q <= 1'b0;
    end else begin
      if (cw_en) begin
        cvld_q[cw_addr] <= 1'b1;
      end
      if (cmd_i.hist_we) begin
        hvld_q[hist_waddr_i] <= 1'b1;
      end
      cvld_rd_q <= cvld_q[coef_raddr_i];
      cb0_rd_q  <= cmd_i.coef_b0;
      hvld_rd_q <= hvld_q[hist_raddr_i];
    end
  end

  assign coef_rd = cvld_rd_q ? $signed(cram_rd) :
                   (cb0_rd_q ? fbpeq_pkg::COEF_ONE : '0);
  assign hist_rd = hvld_rd_q ? $signed(hram_rd) : '0;

  always_comb begin
    unique case (cmd_i.hw_sel)
      fbpeq_pkg::HW_H0: hist_wdata = h0_q;
      fbpeq_pkg::HW_X:  hist_wdata = x_q;
      fbpeq_pkg::HW_H2: hist_wdata = h2_q;
      fbpeq_pkg::HW_Y:  hist_wdata = y_sat;
    endcase
  end

  // ---------------- multiplier ----------------
  assign dry_sel = cmd_i.ch ? dry_r_q : dry_l_q;

  always_comb begin
    unique case (cmd_i.a_sel)
      fbpeq_pkg::A_COEF: mul_a = fbpeq_pkg::MUL_A_W'(coef_rd);
      fbpeq_pkg::A_X:    mul_a = fbpeq_pkg::MUL_A_W'(x_q);
      fbpeq_pkg::A_DRY:  mul_a = fbpeq_pkg::MUL_A_W'(dry_sel);
      fbpeq_pkg::A_W:    mul_a = w_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.b_sel)
      fbpeq_pkg::B_X:    mul_b = x_q;
      fbpeq_pkg::B_HIST: mul_b = hist_rd;
      fbpeq_pkg::B_GAIN:
        mul_b = $signed({{(fbpeq_pkg::MUL_B_W-fbpeq_pkg::GAIN_W){1'b0}}, gain_q});
      fbpeq_pkg::B_INVM:
        mul_b = $signed({{(fbpeq_pkg::MUL_B_W-fbpeq_pkg::MIX_W){1'b0}}, inv_m});
      fbpeq_pkg::B_M:
        mul_b = $signed({{(fbpeq_pkg::MUL_B_W-fbpeq_pkg::MIX_W){1'b0}}, mix_m});
      default: mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------- accumulator ----------------
  always_comb begin
    unique case (cmd_i.acc_op)
      fbpeq_pkg::ACC_HOLD:      acc_d = acc_q;
      fbpeq_pkg::ACC_INIT_BQ:   acc_d = fbpeq_pkg::ACC_HALF_BQ;
      fbpeq_pkg::ACC_INIT_GAIN: acc_d = fbpeq_pkg::ACC_HALF_GAIN;
      fbpeq_pkg::ACC_INIT_MIX:  acc_d = fbpeq_pkg::ACC_HALF_MIX;
      fbpeq_pkg::ACC_ADD:       acc_d = acc_q + ACC_W'(prod_q);
      fbpeq_pkg::ACC_SUB:       acc_d = acc_q - ACC_W'(prod_q);
      default:                  acc_d = acc_q;
    endcase
  end

  // biquad output: floor(acc / 2^28), saturated to a history word
  assign ysh   = $signed(acc_q[ACC_W-1:fbpeq_pkg::COEF_FRAC]);
  assign y_sat = ((&ysh[YSH_W-1:HW-1]) || !(|ysh[YSH_W-1:HW-1])) ? ysh[HW-1:0] :
                 (ysh[YSH_W-1] ? fbpeq_pkg::HIST_MIN : fbpeq_pkg::HIST_MAX);

  // mixed output: floor(acc / 2^16), saturated to the sample width
  assign osh   = $signed(acc_q[ACC_W-1:fbpeq_pkg::MIX_FRAC]);
  assign o_sat = ((&osh[OSH_W-1:SB-1]) || !(|osh[OSH_W-1:SB-1])) ? osh[SB-1:0] :
                 {osh[OSH_W-1], {(SB-1){~osh[OSH_W-1]}}};

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    acc_q  <= acc_d;
    if (cmd_i.in_take && (in_item_i.kind == fbpeq_pkg::KIND_SAMPLE)) begin
      dry_l_q <= in_item_i.left_in;
      dry_r_q <= in_item_i.right_in;
      x_q     <= HW'(in_item_i.left_in);
    end else if (cmd_i.x_load) begin
      x_q <= HW'(dry_r_q);
    end else if (cmd_i.y_fin) begin
      x_q <= y_sat;
    end
    if (cmd_i.h0_cap) begin
      h0_q <= hist_rd;
    end
    if (cmd_i.h2_cap) begin
      h2_q <= hist_rd;
    end
    if (cmd_i.w_load) begin
      w_q <= $signed(acc_q[fbpeq_pkg::GAIN_FRAC+fbpeq_pkg::W_W-1:fbpeq_pkg::GAIN_FRAC]);
    end
    if (cmd_i.res_load) begin
      res_l_q <= o_sat;
    end
    if (cmd_i.out_load) begin
      out_q.left_out  <= res_l_q;
      out_q.right_out <= o_sat;
    end
  end

  assign out_item_o = out_q;

endmodule

// File: hdl/four_band_peaking_eq_stereo_unit.sv
// ----------------------------------------------------------------------------
// four_band_peaking_eq_stereo_unit
// Stereo biquad-cascade equalizer with output gain and dry/wet mix.
// ----------------------------------------------------------------------------
// Each sample-pair item runs left then right through NUM_BANDS direct-form-I
// biquads (Q3.28 coefficients shared by both channels, 32-bit history per
// channel), a Q2.13 output gain and a Q1.16 dry/wet mix, then saturates to
// the sample width. All arithmetic goes through one 34x32 multiplier feeding
// an exact 67-bit accumulator; no new item is taken until the sample pair's
// result is published. The biquad step is set by the registered reads of
// the coefficient and history RAMs and the registered product. A
// coefficient-write item produces no result. Stores come up in pass-through
// (b0 = 1.0, zero history) at reset through per-entry valid flags, so there
// is no clearing pass. Registers: index 0 output_gain, index 1 wet_mix; they
// are to be written only while idle, which the block does not enforce. The
// output register lets a finished result wait while the next item is
// accepted.
// ----------------------------------------------------------------------------
module four_band_peaking_eq_stereo_unit #(
  parameter int NUM_BANDS = fbpeq_pkg::NUM_BANDS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  fbpeq_pkg::eq_in_t                in_item_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output fbpeq_pkg::eq_out_t               out_item_o,
  // register writes
  input  logic                             cfg_we_i,
  input  logic [fbpeq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fbpeq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int COEF_AW = $clog2(NUM_BANDS * fbpeq_pkg::NUM_SLOTS);
  localparam int HIST_AW = $clog2(2 * NUM_BANDS * fbpeq_pkg::HIST_WORDS);

  fbpeq_pkg::eq_cmd_t   cmd;
  logic [COEF_AW-1:0]   coef_raddr;
  logic [HIST_AW-1:0]   hist_raddr;
  logic [HIST_AW-1:0]   hist_waddr;

  // Sequencer: one band = 8 steps (5 reads, 5 MACs, 4 history writes),
  // then 6 steps of gain and mix per channel.
  fbpeq_ctrl #(
    .NUM_BANDS (NUM_BANDS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_kind_i    (in_item_i.kind),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .coef_raddr_o (coef_raddr),
    .hist_raddr_o (hist_raddr),
    .hist_waddr_o (hist_waddr)
  );

  // Datapath: multiplier, accumulator, stores, registers, output register.
  fbpeq_dpath #(
    .NUM_BANDS (NUM_BANDS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_item_i    (in_item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .coef_raddr_i (coef_raddr),
    .hist_raddr_i (hist_raddr),
    .hist_waddr_i (hist_waddr),
    .out_item_o   (out_item_o)
  );

endmodule

// File: hdl/fbpeq_checker.sv
// ----------------------------------------------------------------------------
// fbpeq_checker
// Port-level checks on the stereo EQ, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbpeq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input fbpeq_pkg::eq_in_t                in_item_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input fbpeq_pkg::eq_out_t               out_item_o,
  input logic                             cfg_we_i,
  input logic [fbpeq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [fbpeq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // stalled result holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "result dropped or changed while stalled")

  // a sample item keeps the block busy past the accept cycle
  `ASSERT_CLK(a_busy_after_sample, clk_i, rst_ni, in_valid_i && in_ready_o && (in_item_i.kind == fbpeq_pkg::KIND_SAMPLE) |=> !in_ready_o, "ready after sample accept")

  // coefficient writes never produce a result
  `ASSERT_CLK(a_coef_no_result, clk_i, rst_ni, in_valid_i && in_ready_o && (in_item_i.kind == fbpeq_pkg::KIND_COEF) && !out_valid_o |=> !out_valid_o, "result after coefficient write")

  // no result during reset
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind four_band_peaking_eq_stereo_unit fbpeq_checker u_fbpeq_checker (.*);
